// ===== rtl/core/frd_pkg.sv =====
`timescale 1ns / 1ps
// frd_pkg: shared widths and reset constants for fraction_reduce_bounded
// used by the top level and by the shared divider and multiplier
package frd_pkg;

  localparam int DataW = 64;
  localparam int LimW = 63;
  localparam int ProdW = 2 * DataW;
  localparam int TermWidthDef = 64;
  localparam logic [LimW-1:0] LimReset = 63'd2147483647;

endpackage

// ===== rtl/core/frd_div.sv =====
`timescale 1ns / 1ps
// frd_div: restoring unsigned divider, one quotient bit per cycle
// depends on frd_pkg for the data width
module frd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [frd_pkg::DataW-1:0]  dividend,
  input  logic [frd_pkg::DataW-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [frd_pkg::DataW-1:0]  quotient,
  output logic [frd_pkg::DataW-1:0]  remainder
);

  localparam int CntW = $clog2(frd_pkg::DataW + 1);

  logic [CntW-1:0]             cnt;
  logic [frd_pkg::DataW-1:0]   quo;
  logic [frd_pkg::DataW-1:0]   rem;
  logic [frd_pkg::DataW-1:0]   dvs;
  logic [frd_pkg::DataW:0]     shifted;
  logic [frd_pkg::DataW:0]     diff;
  logic                        ge;

  assign shifted = {rem, quo[frd_pkg::DataW-1]};
  assign diff = shifted - {1'b0, dvs};
  assign ge = !diff[frd_pkg::DataW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(frd_pkg::DataW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[frd_pkg::DataW-1:0] : shifted[frd_pkg::DataW-1:0];
      quo <= {quo[frd_pkg::DataW-2:0], ge};
    end
  end

  assign quotient = quo;
  assign remainder = rem;

endmodule

// ===== rtl/core/frd_mul.sv =====
`timescale 1ns / 1ps
// frd_mul: shift-add unsigned multiplier, one multiplier bit per cycle
// depends on frd_pkg for the data and product widths
module frd_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [frd_pkg::DataW-1:0]  op_a,
  input  logic [frd_pkg::DataW-1:0]  op_b,
  output logic                       busy,
  output logic                       done,
  output logic [frd_pkg::ProdW-1:0]  product
);

  localparam int CntW = $clog2(frd_pkg::DataW + 1);

  logic [CntW-1:0]             cnt;
  logic [frd_pkg::ProdW-1:0]   prod;
  logic [frd_pkg::DataW-1:0]   mcand;
  logic [frd_pkg::DataW:0]     sum;

  assign sum = {1'b0, prod[frd_pkg::ProdW-1:frd_pkg::DataW]}
             + (prod[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(frd_pkg::DataW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{frd_pkg::DataW{1'b0}}, op_b};
      mcand <= op_a;
    end else if (busy) begin
      prod <= {sum, prod[frd_pkg::DataW-1:1]};
    end
  end

  assign product = prod;

endmodule

// ===== rtl/core/fraction_reduce_bounded.sv =====
`timescale 1ns / 1ps
// fraction_reduce_bounded: bounded rational reduction by euclid and continued fractions
// shared units: one division per gcd round, two per reduction, one division and two
// multiplies per expansion round
// throughput: one transaction at a time, in_stall high from acceptance to result load
// zero denominator: goes straight to the result state with 0/0. reset: control clears, term_limit returns to 2147483647
module fraction_reduce_bounded #(
  parameter int TERM_WIDTH = frd_pkg::TermWidthDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [frd_pkg::LimW-1:0]          cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [frd_pkg::DataW-1:0]  in_numerator,
  input  logic signed [frd_pkg::DataW-1:0]  in_denominator,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [frd_pkg::DataW-1:0]  out_numerator,
  output logic [frd_pkg::LimW-1:0]          out_denominator
);

  localparam int DW = frd_pkg::DataW;
  localparam int PW = frd_pkg::ProdW;
  localparam int NS = 21;
  localparam logic [DW-1:0] TermMask = {DW{1'b1}} >> (DW - TERM_WIDTH);

  typedef enum logic [NS-1:0] {
    S_IDLE  = NS'(1) << 0,
    S_GCD   = NS'(1) << 1,
    S_GCDW  = NS'(1) << 2,
    S_DIVN  = NS'(1) << 3,
    S_DIVD  = NS'(1) << 4,
    S_FIT   = NS'(1) << 5,
    S_CF    = NS'(1) << 6,
    S_CFDIV = NS'(1) << 7,
    S_CFMP  = NS'(1) << 8,
    S_CFMQ  = NS'(1) << 9,
    S_B1    = NS'(1) << 10,
    S_B1W   = NS'(1) << 11,
    S_B2    = NS'(1) << 12,
    S_B2W   = NS'(1) << 13,
    S_M1    = NS'(1) << 14,
    S_M1W   = NS'(1) << 15,
    S_M2W   = NS'(1) << 16,
    S_M3W   = NS'(1) << 17,
    S_M4W   = NS'(1) << 18,
    S_M5W   = NS'(1) << 19,
    S_OUT   = NS'(1) << 20
  } state_t;

  state_t state;

  logic [frd_pkg::LimW-1:0] term_limit;
  logic [DW-1:0] lim;
  logic [DW-1:0] n, d, a, b, p0, p1, q0, q1, x, xp, xq, res_n, res_d;
  logic [PW-1:0] acc;
  logic          exc, neg;

  logic [DW-1:0] raw_n, raw_d, mag_n, mag_d;
  logic          sgn_n, sgn_d;

  logic          div_go, div_busy, div_done;
  logic [DW-1:0] div_dvd, div_dvs, div_quo, div_rem;
  logic          mul_go, mul_busy, mul_done;
  logic [DW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_prod;

  function automatic logic over(input logic [PW-1:0] prod, input logic [DW-1:0] k0,
                                input logic [DW-1:0] lv);
    logic [PW:0] s;
    s = {1'b0, prod} + {{(PW-DW+1){1'b0}}, k0};
    return s > {{(PW-DW+1){1'b0}}, lv};
  endfunction

  assign lim = {1'b0, term_limit};
  assign raw_n = in_numerator & TermMask;
  assign raw_d = in_denominator & TermMask;
  assign sgn_n = raw_n[TERM_WIDTH-1];
  assign sgn_d = raw_d[TERM_WIDTH-1];
  assign mag_n = sgn_n ? ((~raw_n + 1'b1) & TermMask) : raw_n;
  assign mag_d = sgn_d ? ((~raw_d + 1'b1) & TermMask) : raw_d;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      term_limit <= frd_pkg::LimReset;
    end else if (cfg_we) begin
      term_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_go <= 1'b0;
      mul_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      mul_go <= 1'b0;
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            n <= mag_n;
            d <= mag_d;
            a <= mag_n;
            b <= mag_d;
            neg <= sgn_n ^ sgn_d;
            if (mag_d == '0) begin
              res_n <= '0;
              res_d <= '0;
              neg <= 1'b0;
              state <= S_OUT;
            end else begin
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          div_go <= 1'b1;
          if (b == '0) begin
            div_dvd <= n;
            div_dvs <= a;
            state <= S_DIVN;
          end else begin
            div_dvd <= a;
            div_dvs <= b;
            state <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (div_done) begin
            a <= b;
            b <= div_rem;
            state <= S_GCD;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            n <= div_quo;
            div_go <= 1'b1;
            div_dvd <= d;
            div_dvs <= a;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            d <= div_quo;
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (n <= lim && d <= lim) begin
            res_n <= n;
            res_d <= d;
            state <= S_OUT;
          end else begin
            p0 <= '0;
            q0 <= DW'(1);
            p1 <= DW'(1);
            q1 <= '0;
            state <= S_CF;
          end
        end
        S_CF: begin
          if (d == '0) begin
            res_n <= p1;
            res_d <= q1;
            state <= S_OUT;
          end else begin
            div_go <= 1'b1;
            div_dvd <= n;
            div_dvs <= d;
            state <= S_CFDIV;
          end
        end
        S_CFDIV: begin
          if (div_done) begin
            x <= div_quo;
            b <= div_rem;
            mul_go <= 1'b1;
            mul_a <= div_quo;
            mul_b <= p1;
            state <= S_CFMP;
          end
        end
        S_CFMP: begin
          if (mul_done) begin
            xp <= mul_prod[DW-1:0];
            exc <= over(mul_prod, p0, lim);
            mul_go <= 1'b1;
            mul_a <= x;
            mul_b <= q1;
            state <= S_CFMQ;
          end
        end
        S_CFMQ: begin
          if (mul_done) begin
            if (exc || over(mul_prod, q0, lim)) begin
              state <= S_B1;
            end else begin
              p0 <= p1;
              q0 <= q1;
              p1 <= xp + p0;
              q1 <= mul_prod[DW-1:0] + q0;
              n <= d;
              d <= b;
              state <= S_CF;
            end
          end
        end
        S_B1: begin
          if (p1 != '0) begin
            if (p0 <= lim) begin
              div_go <= 1'b1;
              div_dvd <= lim - p0;
              div_dvs <= p1;
              state <= S_B1W;
            end else begin
              x <= '0;
              state <= S_B2;
            end
          end else begin
            state <= S_B2;
          end
        end
        S_B1W: begin
          if (div_done) begin
            x <= div_quo;
            state <= S_B2;
          end
        end
        S_B2: begin
          if (q1 != '0) begin
            if (q0 <= lim) begin
              div_go <= 1'b1;
              div_dvd <= lim - q0;
              div_dvs <= q1;
              state <= S_B2W;
            end else begin
              x <= '0;
              state <= S_M1;
            end
          end else begin
            state <= S_M1;
          end
        end
        S_B2W: begin
          if (div_done) begin
            if (div_quo < x) begin
              x <= div_quo;
            end
            state <= S_M1;
          end
        end
        S_M1: begin
          mul_go <= 1'b1;
          mul_a <= x;
          mul_b <= q1;
          state <= S_M1W;
        end
        S_M1W: begin
          if (mul_done) begin
            xq <= mul_prod[DW-1:0];
            mul_go <= 1'b1;
            mul_a <= d;
            mul_b <= mul_prod[DW-1:0];
            state <= S_M2W;
          end
        end
        S_M2W: begin
          if (mul_done) begin
            acc <= {mul_prod[PW-2:0], 1'b0};
            mul_go <= 1'b1;
            mul_a <= d;
            mul_b <= q0;
            state <= S_M3W;
          end
        end
        S_M3W: begin
          if (mul_done) begin
            acc <= acc + mul_prod;
            mul_go <= 1'b1;
            mul_a <= n;
            mul_b <= q1;
            state <= S_M4W;
          end
        end
        S_M4W: begin
          if (mul_done) begin
            if (acc > mul_prod) begin
              mul_go <= 1'b1;
              mul_a <= x;
              mul_b <= p1;
              state <= S_M5W;
            end else begin
              res_n <= p1;
              res_d <= q1;
              state <= S_OUT;
            end
          end
        end
        S_M5W: begin
          if (mul_done) begin
            res_n <= mul_prod[DW-1:0] + p0;
            res_d <= xq + q0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_numerator <= neg ? (DW'(0) - res_n) : res_n;
            out_denominator <= res_d[frd_pkg::LimW-1:0];
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  frd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  frd_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_go),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_prod)
  );

  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && mag_d == '0) |=> state == S_OUT)
    else $error("zero denominator did not go straight to result");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_go |-> !div_busy)
    else $error("divider started while busy");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_go |-> !mul_busy)
    else $error("multiplier started while busy");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (div_busy || mul_busy) |-> in_stall)
    else $error("input open while a shared unit is busy");

endmodule

// ===== sim/frd_checker.sv =====
`timescale 1ns / 1ps
// frd_checker: watches the channels of fraction_reduce_bounded, predicts each reduced fraction
// and compares it with the block's result; depends on frd_pkg
module frd_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [frd_pkg::LimW-1:0]          cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [frd_pkg::DataW-1:0]  in_numerator,
  input  logic signed [frd_pkg::DataW-1:0]  in_denominator,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [frd_pkg::DataW-1:0]  out_numerator,
  input  logic [frd_pkg::LimW-1:0]          out_denominator,
  output int                                failures,
  output int                                pending,
  output int                                results
);

  typedef struct packed {
    logic [frd_pkg::DataW-1:0] num;
    logic [frd_pkg::LimW-1:0]  den;
  } frac_t;

  frac_t reduced_q[$];
  logic [frd_pkg::LimW-1:0] limit;

  function automatic bit over_limit(logic [63:0] x, logic [63:0] k1, logic [63:0] k0,
                                    logic [63:0] lim);
    if (k0 > lim) return 1'b1;
    return k1 != 0 && x > (lim - k0) / k1;
  endfunction

  function automatic frac_t predict_fraction(logic [63:0] a, logic [63:0] b,
                                             logic [frd_pkg::LimW-1:0] lim63);
    logic [63:0] lim, n, d, u, v, t, x, r, p0, q0, p1, q1, p2, q2, bnd;
    logic [127:0] lhs, rhs;
    logic nneg, dneg;
    bit done;
    frac_t f;
    lim = {1'b0, lim63};
    nneg = a[63];
    dneg = b[63];
    n = nneg ? -a : a;
    d = dneg ? -b : b;
    if (d == 0) begin
      f.num = '0;
      f.den = '0;
      return f;
    end
    u = n;
    v = d;
    while (v != 0) begin
      t = u % v;
      u = v;
      v = t;
    end
    n = n / u;
    d = d / u;
    if (n <= lim && d <= lim) begin
      p1 = n;
      q1 = d;
    end else begin
      p0 = 0; q0 = 1; p1 = 1; q1 = 0;
      done = 0;
      while (d != 0 && !done) begin
        x = n / d;
        r = n % d;
        if (over_limit(x, p1, p0, lim) || over_limit(x, q1, q0, lim)) begin
          if (p1 != 0) x = (p0 <= lim) ? (lim - p0) / p1 : 0;
          if (q1 != 0) begin
            bnd = (q0 <= lim) ? (lim - q0) / q1 : 0;
            if (bnd < x) x = bnd;
          end
          t = x * q1;
          lhs = (({64'b0, d} * {64'b0, t}) << 1) + {64'b0, d} * {64'b0, q0};
          rhs = {64'b0, n} * {64'b0, q1};
          if (lhs > rhs) begin
            p1 = x * p1 + p0;
            q1 = x * q1 + q0;
          end
          done = 1;
        end else begin
          p2 = x * p1 + p0;
          q2 = x * q1 + q0;
          p0 = p1; q0 = q1; p1 = p2; q1 = q2;
          n = d;
          d = r;
        end
      end
    end
    f.num = (nneg != dneg) ? -p1 : p1;
    f.den = q1[62:0];
    return f;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", field, got, want, results);
    failures++;
  endtask

  initial begin
    failures = 0;
    results = 0;
    pending = 0;
    limit = frd_pkg::LimReset;
  end

  always @(posedge clk) begin
    frac_t want;
    if (rst) begin
      limit = frd_pkg::LimReset;
    end else begin
      if (in_valid && !in_stall)
        reduced_q.push_back(predict_fraction(in_numerator, in_denominator, limit));
      if (out_valid && !out_stall) begin
        if (reduced_q.size() == 0) begin
          $display("unexpected transaction %0d/%0d", out_numerator, out_denominator);
          failures++;
        end else begin
          want = reduced_q.pop_front();
          if (out_numerator !== want.num) report("numerator", out_numerator, want.num);
          if (out_denominator !== want.den)
            report("denominator", {1'b0, out_denominator}, {1'b0, want.den});
        end
        results++;
      end
      if (cfg_we) limit = cfg_wdata;
    end
    pending = reduced_q.size();
  end

endmodule

// ===== sim/tb_fraction_reduce_bounded.sv =====
`timescale 1ns / 1ps
// tb_fraction_reduce_bounded: stimulus, stalls and verdict for fraction_reduce_bounded
// depends on frd_pkg, the block and frd_checker
module tb_fraction_reduce_bounded;

  localparam logic [63:0] MostNeg = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxPos = 64'h7fff_ffff_ffff_ffff;
  localparam int IdleLimit = 400000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [frd_pkg::LimW-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [63:0] in_numerator = '0;
  logic signed [63:0] in_denominator = '0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [63:0] out_numerator;
  logic [frd_pkg::LimW-1:0] out_denominator;
  int failures, pending, results;
  int stall_left = 0;
  int idle_cycles = 0;
  int sent = 0;
  bit quiet = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  fraction_reduce_bounded dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_numerator(in_numerator), .in_denominator(in_denominator),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_numerator(out_numerator), .out_denominator(out_denominator)
  );

  frd_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_numerator(in_numerator), .in_denominator(in_denominator),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_numerator(out_numerator), .out_denominator(out_denominator),
    .failures(failures), .pending(pending), .results(results)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) stall_left = quiet ? 0 : $urandom_range(0, 4);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("FAIL fraction_reduce_bounded");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1;
      stall_left--;
    end else begin
      out_stall = 0;
    end
  end

  function automatic logic [63:0] wide_rand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (v == MostNeg) v = MostNeg + 1;
    return v;
  endfunction

  function automatic logic [63:0] signed_of(logic [63:0] mag);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send(logic [63:0] n, logic [63:0] d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    in_numerator = n;
    in_denominator = d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
    sent++;
  endtask

  task automatic set_limit(logic [62:0] v);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_item(logic [62:0] lim);
    logic [63:0] n, d, g;
    int shift;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = wide_rand();
        d = wide_rand();
      end
      3, 4: begin
        n = signed_of($urandom_range(0, 1000));
        d = signed_of($urandom_range(1, 1000));
      end
      5: begin
        g = $urandom_range(2, 5000);
        n = signed_of(g * $urandom_range(1, 1 << 30));
        d = signed_of(g * $urandom_range(1, 1 << 30));
      end
      6: begin
        n = signed_of({1'b0, lim} + $urandom_range(0, 3) - 1);
        d = signed_of({1'b0, lim} + $urandom_range(0, 5));
      end
      7: begin
        n = $urandom_range(0, 1) ? 64'd0 : wide_rand();
        d = $urandom_range(0, 1) ? 64'd0 : wide_rand();
      end
      default: begin
        shift = $urandom_range(1, 63);
        n = signed_of(wide_rand() >> shift);
        shift = $urandom_range(1, 63);
        d = signed_of(wide_rand() >> shift);
      end
    endcase
    send(n, d);
  endtask

  logic [62:0] limits[9];

  initial begin
    limits = '{63'd2147483647, 63'd1, 63'd7, 63'd255, 63'd65535, 63'd1 << 40,
               63'h7fff_ffff_ffff_ffff, 63'd1000, 63'd0};
    limits[8] = 63'({$urandom, $urandom}) | 63'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // zero denominators, zero numerators, sign combinations, extremes
    send(64'd0, 64'd0);
    send(64'd5, 64'd0);
    send(-64'd9, 64'd0);
    send(64'd0, 64'd7);
    send(64'd0, -64'd7);
    send(64'd6, -64'd4);
    send(-64'd12, -64'd18);
    send(-MaxPos, MaxPos);
    send(MaxPos, 64'd1);
    send(64'd1, -MaxPos);
    send(MaxPos, MaxPos - 1);
    send(-MaxPos, MaxPos - 2);
    send(64'd3141592653589793, 64'd1000000000000000);
    send(64'h5555_5555_5555_5555, 64'h2aaa_aaaa_aaaa_aaab);
    send(64'd2147483647, 64'd2147483648);
    send(64'd1, 64'd1);
    send(-64'd1, 64'd1);
    send(64'hffff_ffff_ffff, -64'd3);

    foreach (limits[p]) begin
      set_limit(limits[p]);
      quiet = (p % 3 == 2);
      send(-MaxPos, 64'd3);
      send(MaxPos, MaxPos - 1);
      repeat (62) random_item(limits[p]);
    end
    quiet = 0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("run covered %0d fractions with %0d results over %0d term limits", sent, results,
             $size(limits));
    if (failures == 0 && pending == 0) begin
      $display("PASS fraction_reduce_bounded");
    end else begin
      $display("FAIL fraction_reduce_bounded");
    end
    $finish;
  end

endmodule
